// ===== rtl/arx_pkg.sv =====
// Package for the ARX counter-mode stream cipher.
// Holds constants, register indexes, state enum and the quarter-round helpers.
package arx_pkg;

    localparam int unsigned DoubleRoundCount = 10;
    localparam int unsigned ExtraSubBlocks   = 3;
    localparam logic [31:0] StateConst       = 32'h43686143;
    localparam int unsigned WordW            = 32;
    localparam int unsigned ChunkW           = 8 * WordW;
    localparam int unsigned CfgIdxW          = 3;

    localparam logic [CfgIdxW-1:0] RegKey0   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegKey1   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegKey2   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegKey3   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegNonce0 = 3'd4;
    localparam logic [CfgIdxW-1:0] RegNonce1 = 3'd5;

    typedef logic [WordW-1:0] t_word;
    typedef t_word [7:0]      t_chunk;

    typedef enum logic [1:0] {
        t_ST_IDLE,
        t_ST_ROUND,
        t_ST_OUT
    } t_state;

    typedef struct packed {
        logic   gen;
        t_chunk data;
    } t_job;

    function automatic t_word rotl(input t_word v, input int unsigned s);
        return (v << s) | (v >> (WordW - s));
    endfunction

    // one full quarter-round on words a, b, c, d
    function automatic logic [4*WordW-1:0] quarter(input t_word a, input t_word b,
                                                   input t_word c, input t_word d);
        t_word a1, b1, c1, d1;
        a1 = a + b;   d1 = rotl(d ^ a1, 16);
        c1 = c + d1;  b1 = rotl(b ^ c1, 12);
        a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
        c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
        return {d1, c1, b1, a1};
    endfunction

endpackage

// ===== rtl/arx_stream_cipher_ctr.sv =====
// ARX counter-mode stream cipher, top level.
// A chunk that reuses stored keystream goes straight to the output stage; one that
// starts a run first waits for the rounds (R double rounds, E extra sub-blocks).
// The engine takes one chunk at a time. The rounds run on the two shared
// quarter-round units (one column or diagonal pass per cycle).
// Reset (synchronous, active low) clears key, nonce, counter and sub-block index.
module arx_stream_cipher_ctr
    import arx_pkg::*;
#(
    parameter int unsigned DOUBLE_ROUND_COUNT = DoubleRoundCount,
    parameter int unsigned EXTRA_SUB_BLOCKS   = ExtraSubBlocks
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [WordW-1:0]   i_cfg_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [ChunkW-1:0]  s_axis_tdata,   // data_word_0 .. data_word_7
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [ChunkW-1:0]  m_axis_tdata    // cipher_word_0 .. cipher_word_7
);
    logic   push, full, pop, qvalid;
    t_job   fjob, qjob;
    t_chunk odata;

    assign o_cfg_ready = 1'b1;

    arx_front #(.EXTRA_SUB_BLOCKS(EXTRA_SUB_BLOCKS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(t_chunk'(s_axis_tdata)),
        .o_push(push), .o_job(fjob), .i_full(full)
    );

    arx_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_job(fjob), .o_full(full),
        .i_pop(pop), .o_valid(qvalid), .o_job(qjob)
    );

    arx_engine #(
        .DOUBLE_ROUND_COUNT(DOUBLE_ROUND_COUNT),
        .EXTRA_SUB_BLOCKS(EXTRA_SUB_BLOCKS)
    ) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_job_valid(qvalid), .i_job(qjob), .o_pop(pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(odata)
    );

    assign m_axis_tdata = ChunkW'(odata);
endmodule

// ===== rtl/arx_front.sv =====
// Front end: accepts chunk beats, tags those that start a keystream run.
// Depends on arx_pkg.
module arx_front
    import arx_pkg::*;
#(
    parameter int unsigned EXTRA_SUB_BLOCKS = ExtraSubBlocks
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_chunk i_data,
    output logic   o_push,
    output t_job   o_job,
    input  logic   i_full
);
    localparam int unsigned IdxW = (EXTRA_SUB_BLOCKS > 0) ? $clog2(EXTRA_SUB_BLOCKS + 1) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(EXTRA_SUB_BLOCKS);

    logic [IdxW-1:0] r_idx, n_idx;

    assign o_ready    = !i_full;
    assign o_push     = i_valid && !i_full;
    assign o_job.gen  = (r_idx == '0);
    assign o_job.data = i_data;
    assign n_idx      = (r_idx == LastIdx) ? '0 : r_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (o_push) begin
            r_idx <= n_idx;
        end
    end
endmodule

// ===== rtl/arx_queue.sv =====
// Two-entry job queue between the front end and the keystream engine.
// Depends on arx_pkg.
module arx_queue
    import arx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ===== rtl/arx_engine.sv =====
// Back end: runs the rounds with two quarter-round units, keeps the
// keystream store and XORs chunks into output beats. Depends on arx_pkg.
module arx_engine
    import arx_pkg::*;
#(
    parameter int unsigned DOUBLE_ROUND_COUNT = DoubleRoundCount,
    parameter int unsigned EXTRA_SUB_BLOCKS   = ExtraSubBlocks
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_valid,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  t_word  i_cfg_data,
    input  logic   i_job_valid,
    input  t_job   i_job,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_ready,
    output t_chunk o_data
);
    localparam int unsigned SubBlocks = EXTRA_SUB_BLOCKS + 1;
    localparam int unsigned Steps     = 2 * (DOUBLE_ROUND_COUNT + EXTRA_SUB_BLOCKS);
    localparam int unsigned StepW     = $clog2(Steps + 1);
    localparam int unsigned SbW       = (SubBlocks > 1) ? $clog2(SubBlocks) : 1;
    localparam int unsigned AddrW     = SbW + 3;
    localparam int unsigned FirstOut  = 2 * DOUBLE_ROUND_COUNT;

    t_state r_state, n_state;
    t_word  r_key [4];
    t_word  r_nonce [2];
    t_word  r_ctr;
    t_chunk r_init, r_w, n_w;
    t_chunk r_data;
    logic [StepW-1:0] r_step;
    logic [SbW-1:0]   r_wsb, r_rsb;
    t_word  r_ks [SubBlocks*8];
    t_chunk r_out;
    logic   r_ovalid;
    logic   done_dr, wr_ks;
    logic [4*WordW-1:0] q0, q1;
    logic   out_free, load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= '0; r_key[1] <= '0; r_key[2] <= '0; r_key[3] <= '0;
            r_nonce[0] <= '0; r_nonce[1] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegKey0:   r_key[0]   <= i_cfg_data;
                RegKey1:   r_key[1]   <= i_cfg_data;
                RegKey2:   r_key[2]   <= i_cfg_data;
                RegKey3:   r_key[3]   <= i_cfg_data;
                RegNonce0: r_nonce[0] <= i_cfg_data;
                RegNonce1: r_nonce[1] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // even step: column pass, odd step: diagonal pass
    always_comb begin
        n_w = r_w;
        if (!r_step[0]) begin
            q0 = quarter(r_w[0], r_w[1], r_w[2], r_w[3]);
            q1 = quarter(r_w[4], r_w[5], r_w[6], r_w[7]);
            {n_w[3], n_w[2], n_w[1], n_w[0]} = q0;
            {n_w[7], n_w[6], n_w[5], n_w[4]} = q1;
        end else begin
            q0 = quarter(r_w[0], r_w[5], r_w[2], r_w[7]);
            q1 = quarter(r_w[1], r_w[6], r_w[3], r_w[4]);
            {n_w[7], n_w[2], n_w[5], n_w[0]} = q0;
            {n_w[4], n_w[3], n_w[6], n_w[1]} = q1;
        end
    end

    assign done_dr  = (r_state == t_ST_ROUND) && r_step[0];
    assign wr_ks    = done_dr && (r_step + 1'b1 >= StepW'(FirstOut));
    assign out_free = !r_ovalid || i_ready;
    assign load     = (r_state == t_ST_IDLE) && i_job_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            t_ST_IDLE:  if (i_job_valid) n_state = i_job.gen ? t_ST_ROUND : t_ST_OUT;
            t_ST_ROUND: if (r_step == StepW'(Steps - 1)) n_state = t_ST_OUT;
            t_ST_OUT:   if (out_free) n_state = t_ST_IDLE;
            default:    n_state = t_ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == t_ST_OUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_job.data;
            if (i_job.gen) begin
                r_init <= {StateConst, r_nonce[1], r_nonce[0], r_ctr,
                           r_key[3], r_key[2], r_key[1], r_key[0]};
                r_w    <= {StateConst, r_nonce[1], r_nonce[0], r_ctr,
                           r_key[3], r_key[2], r_key[1], r_key[0]};
            end
        end else if (r_state == t_ST_ROUND) begin
            r_w <= n_w;
        end
        if (wr_ks) begin
            for (int j = 0; j < 8; j++) begin
                r_ks[AddrW'({r_wsb, 3'(j)})] <= n_w[j] ^ r_init[j];
            end
        end
        if (o_pop) begin
            for (int j = 0; j < 8; j++) begin
                r_out[j] <= r_data[j] ^ r_ks[AddrW'({r_rsb, 3'(j)})];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= t_ST_IDLE;
            r_step   <= '0;
            r_ctr    <= '0;
            r_wsb    <= '0;
            r_rsb    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load && i_job.gen) begin
                r_step <= '0;
                r_wsb  <= '0;
                r_rsb  <= '0;
                r_ctr  <= r_ctr + 1'b1;
            end else if (r_state == t_ST_ROUND) begin
                r_step <= r_step + 1'b1;
                if (wr_ks) r_wsb <= r_wsb + 1'b1;
            end
            if (o_pop) begin
                r_rsb    <= r_rsb + 1'b1;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;
endmodule
